// File: rtl/c6502_pkg.sv
// c6502_pkg: shared types and constants for the 6502 instruction core
// depends on nothing; used by the interfaces, decoder, alu and top level

package c6502_pkg;

  localparam logic [15:0] VEC_NMI    = 16'hFFFA;
  localparam logic [15:0] VEC_RESET  = 16'hFFFC;
  localparam logic [15:0] VEC_IRQ    = 16'hFFFE;
  localparam logic [7:0]  STACK_PAGE = 8'h01;
  localparam logic [7:0]  SP_RESET   = 8'hFD;
  localparam logic [7:0]  P_RESET    = 8'h24;
  localparam logic [7:0]  PULL_MASK  = 8'hEF;
  localparam logic [7:0]  FL_U       = 8'h20;
  localparam logic [7:0]  FL_B       = 8'h10;
  localparam logic [15:0] PAGE_MASK  = 16'hFF00;

  localparam logic [7:0] OPC_BRK = 8'h00;
  localparam logic [7:0] OPC_PHP = 8'h08;
  localparam logic [7:0] OPC_JSR = 8'h20;
  localparam logic [7:0] OPC_PLP = 8'h28;
  localparam logic [7:0] OPC_RTI = 8'h40;
  localparam logic [7:0] OPC_PHA = 8'h48;
  localparam logic [7:0] OPC_JMP = 8'h4C;
  localparam logic [7:0] OPC_RTS = 8'h60;
  localparam logic [7:0] OPC_PLA = 8'h68;
  localparam logic [7:0] OPC_JMI = 8'h6C;

  typedef enum logic [3:0] {
    M_ILL, M_IMP, M_ACC, M_SPC, M_IMM, M_REL, M_ZP, M_ZPX, M_ZPY,
    M_ABS, M_ABX, M_ABY, M_IZX, M_IZY
  } mode_t;

  typedef enum logic [4:0] {
    O_ORA, O_AND, O_EOR, O_ADD, O_STA, O_LDA, O_CPA, O_SUB,
    O_ASL, O_ROL, O_LSR, O_ROR, O_STX, O_LDX, O_DEC, O_INC,
    O_BIT, O_STY, O_LDY, O_CPY, O_CPX, O_NONE
  } op_t;

  typedef enum logic [1:0] {K_INSTR, K_RESET, K_NMI, K_IRQ} kind_t;

  typedef struct packed {
    mode_t mode;
    op_t   op;
  } dec_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] read_data;
    logic       irq_line;
    logic       nmi_pulse;
  } in_item_t;

  typedef struct packed {
    logic [15:0] bus_address;
    logic        bus_write;
    logic [7:0]  write_data;
    logic        instr_end;
    logic        illegal_opcode;
  } out_item_t;

endpackage

// File: rtl/c6502_in_if.sv
// c6502_in_if: request channel into the core, carries one completed bus cycle
// depends on c6502_pkg

interface c6502_in_if;
  logic                 valid;
  logic                 ready;
  c6502_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/c6502_out_if.sv
// c6502_out_if: result channel out of the core, carries the next bus access
// depends on c6502_pkg

interface c6502_out_if;
  logic                 valid;
  logic                 ready;
  c6502_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/c6502_decode.sv
// c6502_decode: opcode to addressing mode and operation
// depends on c6502_pkg

module c6502_decode (
  input  logic [7:0]       opc,
  output c6502_pkg::dec_t  dec
);
  logic [2:0] a, b;
  logic [1:0] c;
  assign a = opc[7:5];
  assign b = opc[4:2];
  assign c = opc[1:0];

  always_comb begin
    dec.mode = c6502_pkg::M_ILL;
    dec.op   = c6502_pkg::O_NONE;
    case (c)
      2'd1: begin
        dec.op = c6502_pkg::op_t'({2'b00, a});
        case (b)
          3'd0: dec.mode = c6502_pkg::M_IZX;
          3'd1: dec.mode = c6502_pkg::M_ZP;
          3'd2: dec.mode = c6502_pkg::M_IMM;
          3'd3: dec.mode = c6502_pkg::M_ABS;
          3'd4: dec.mode = c6502_pkg::M_IZY;
          3'd5: dec.mode = c6502_pkg::M_ZPX;
          3'd6: dec.mode = c6502_pkg::M_ABY;
          default: dec.mode = c6502_pkg::M_ABX;
        endcase
        if (opc == 8'h89) begin
          dec.mode = c6502_pkg::M_ILL;
          dec.op   = c6502_pkg::O_NONE;
        end
      end
      2'd2: begin
        dec.op = c6502_pkg::op_t'({2'b01, a});
        case (b)
          3'd0: dec.mode = (opc == 8'hA2) ? c6502_pkg::M_IMM : c6502_pkg::M_ILL;
          3'd1: dec.mode = c6502_pkg::M_ZP;
          3'd2: begin
            if (a < 3'd4) dec.mode = c6502_pkg::M_ACC;
            else begin
              dec.mode = c6502_pkg::M_IMP;
              dec.op   = c6502_pkg::O_NONE;
            end
          end
          3'd3: dec.mode = c6502_pkg::M_ABS;
          3'd5: dec.mode = (a == 3'd4 || a == 3'd5) ? c6502_pkg::M_ZPY : c6502_pkg::M_ZPX;
          3'd6: begin
            dec.op   = c6502_pkg::O_NONE;
            dec.mode = (opc == 8'h9A || opc == 8'hBA) ? c6502_pkg::M_IMP : c6502_pkg::M_ILL;
          end
          3'd7: begin
            if (a == 3'd4) dec.mode = c6502_pkg::M_ILL;
            else dec.mode = (a == 3'd5) ? c6502_pkg::M_ABY : c6502_pkg::M_ABX;
          end
          default: dec.mode = c6502_pkg::M_ILL;
        endcase
      end
      2'd0: begin
        case (a)
          3'd1: dec.op = c6502_pkg::O_BIT;
          3'd4: dec.op = c6502_pkg::O_STY;
          3'd5: dec.op = c6502_pkg::O_LDY;
          3'd6: dec.op = c6502_pkg::O_CPY;
          3'd7: dec.op = c6502_pkg::O_CPX;
          default: dec.op = c6502_pkg::O_NONE;
        endcase
        case (b)
          3'd0: begin
            if (a < 3'd4) dec.mode = c6502_pkg::M_SPC;
            else dec.mode = (a == 3'd4) ? c6502_pkg::M_ILL : c6502_pkg::M_IMM;
          end
          3'd1: dec.mode = (a == 3'd1 || a >= 3'd4) ? c6502_pkg::M_ZP : c6502_pkg::M_ILL;
          3'd2: dec.mode = (a < 3'd4) ? c6502_pkg::M_SPC : c6502_pkg::M_IMP;
          3'd3: begin
            if (a == 3'd2 || a == 3'd3) dec.mode = c6502_pkg::M_SPC;
            else dec.mode = (a == 3'd0) ? c6502_pkg::M_ILL : c6502_pkg::M_ABS;
          end
          3'd4: dec.mode = c6502_pkg::M_REL;
          3'd5: dec.mode = (a == 3'd4 || a == 3'd5) ? c6502_pkg::M_ZPX : c6502_pkg::M_ILL;
          3'd6: dec.mode = c6502_pkg::M_IMP;
          default: dec.mode = (opc == 8'hBC) ? c6502_pkg::M_ABX : c6502_pkg::M_ILL;
        endcase
      end
      default: ;
    endcase
  end
endmodule

// File: rtl/c6502_alu.sv
// c6502_alu: read-type operations and shift / inc / dec modify unit
// depends on c6502_pkg

module c6502_alu (
  input  c6502_pkg::op_t op,
  input  logic [7:0]     a,
  input  logic [7:0]     x,
  input  logic [7:0]     y,
  input  logic [7:0]     p,
  input  logic [7:0]     v,
  input  logic           rmw,
  output logic [7:0]     a_o,
  output logic [7:0]     x_o,
  output logic [7:0]     y_o,
  output logic [7:0]     p_o,
  output logic [7:0]     res
);
  logic [8:0] sum;
  logic [7:0] opnd, cr, diff;
  logic       cin;

  always_comb begin
    a_o  = a;
    x_o  = x;
    y_o  = y;
    p_o  = p;
    res  = v;
    cin  = p[0];
    opnd = (op == c6502_pkg::O_SUB) ? ~v : v;
    sum  = {1'b0, a} + {1'b0, opnd} + {8'd0, cin};
    cr   = a;
    if (op == c6502_pkg::O_CPX) cr = x;
    if (op == c6502_pkg::O_CPY) cr = y;
    diff = cr - v;
    if (rmw) begin
      case (op)
        c6502_pkg::O_ASL: begin res = {v[6:0], 1'b0}; p_o[0] = v[7]; end
        c6502_pkg::O_ROL: begin res = {v[6:0], cin};  p_o[0] = v[7]; end
        c6502_pkg::O_LSR: begin res = {1'b0, v[7:1]}; p_o[0] = v[0]; end
        c6502_pkg::O_ROR: begin res = {cin, v[7:1]};  p_o[0] = v[0]; end
        c6502_pkg::O_DEC: res = v - 8'd1;
        c6502_pkg::O_INC: res = v + 8'd1;
        default: ;
      endcase
      p_o[1] = (res == 8'd0);
      p_o[7] = res[7];
    end else begin
      case (op)
        c6502_pkg::O_ORA: a_o = a | v;
        c6502_pkg::O_AND: a_o = a & v;
        c6502_pkg::O_EOR: a_o = a ^ v;
        c6502_pkg::O_ADD, c6502_pkg::O_SUB: begin
          a_o    = sum[7:0];
          p_o[0] = sum[8];
          p_o[6] = ~(a[7] ^ opnd[7]) & (a[7] ^ sum[7]);
        end
        c6502_pkg::O_LDA: a_o = v;
        c6502_pkg::O_LDX: x_o = v;
        c6502_pkg::O_LDY: y_o = v;
        default: ;
      endcase
      case (op)
        c6502_pkg::O_ORA, c6502_pkg::O_AND, c6502_pkg::O_EOR, c6502_pkg::O_ADD,
        c6502_pkg::O_SUB, c6502_pkg::O_LDA: begin
          p_o[1] = (a_o == 8'd0); p_o[7] = a_o[7];
        end
        c6502_pkg::O_LDX: begin p_o[1] = (v == 8'd0); p_o[7] = v[7]; end
        c6502_pkg::O_LDY: begin p_o[1] = (v == 8'd0); p_o[7] = v[7]; end
        c6502_pkg::O_CPA, c6502_pkg::O_CPX, c6502_pkg::O_CPY: begin
          p_o[0] = (cr >= v); p_o[1] = (diff == 8'd0); p_o[7] = diff[7];
        end
        c6502_pkg::O_BIT: begin
          p_o[1] = ((a & v) == 8'd0); p_o[7] = v[7]; p_o[6] = v[6];
        end
        default: ;
      endcase
    end
  end
endmodule

// File: rtl/cpu_6502_instruction_core.sv
// cpu_6502_instruction_core: 6502 core without decimal mode, one bus cycle per request
// depends on c6502_pkg, c6502_in_if, c6502_out_if, c6502_decode, c6502_alu
//
// usage
//   in  : one request per completed bus cycle: cmd (1 restarts through the reset
//         vector), read_data for the previous read, irq_line level, nmi_pulse
//   out : one result per request: the next bus access (address, write, data),
//         instr_end on opcode fetches and illegal_opcode after a skipped opcode
//   result: registered, loaded into the result register when a request is accepted
//   throughput: one request per cycle while out.ready is high; all work for
//     a request is a single pass through the decoder and alu between the
//     architectural registers and the result register
//   reset: rst_n clears control state and puts the core at the reset-vector
//     read; no result is pending until the first request arrives
//   stall: while the result register is full and out.ready is low, in.ready
//     drops; a taken result frees the register for a request in the same cycle

module cpu_6502_instruction_core (
  input logic clk,
  input logic rst_n,
  c6502_in_if.sink    in_ch,
  c6502_out_if.source out_ch
);

  // architectural and sequencing state
  logic [7:0]  a_r, x_r, y_r, s_r, p_r, opc_r, dt_r;
  logic [15:0] pc_r, at_r;
  logic [2:0]  ph_r;
  logic        nmi_r;
  c6502_pkg::kind_t kind_r;
  c6502_pkg::out_item_t res_r;
  logic        res_vld_r;

  logic [7:0]  a_nxt, x_nxt, y_nxt, s_nxt, p_nxt, opc_nxt, dt_nxt;
  logic [15:0] pc_nxt, at_nxt;
  logic [2:0]  ph_nxt;
  logic        nmi_nxt;
  c6502_pkg::kind_t kind_nxt;
  c6502_pkg::out_item_t req;

  logic accept;
  assign in_ch.ready  = ~res_vld_r | out_ch.ready;
  assign accept       = in_ch.valid & in_ch.ready;
  assign out_ch.valid = res_vld_r;
  assign out_ch.data  = res_r;

  // decode: fresh byte on fetch cycles, the latched opcode otherwise
  logic [7:0] rd, dec_opc;
  c6502_pkg::dec_t dec;
  assign rd      = in_ch.data.read_data;
  assign dec_opc = (kind_r == c6502_pkg::K_INSTR && ph_r == 3'd0) ? rd : opc_r;
  c6502_decode u_dec (.opc(dec_opc), .dec(dec));

  // alu sees the value to operate on and the flags
  logic [7:0] alu_v, alu_a, alu_x, alu_y, alu_p, alu_res;
  logic       alu_rmw;
  c6502_alu u_alu (
    .op(dec.op), .a(a_r), .x(x_r), .y(y_r), .p(p_r), .v(alu_v), .rmw(alu_rmw),
    .a_o(alu_a), .x_o(alu_x), .y_o(alu_y), .p_o(alu_p), .res(alu_res)
  );
  assign alu_v   = (dec.mode == c6502_pkg::M_ACC) ? a_r : rd;
  assign alu_rmw = (dec.op >= c6502_pkg::O_ASL && dec.op <= c6502_pkg::O_ROR) ||
                   dec.op == c6502_pkg::O_DEC || dec.op == c6502_pkg::O_INC;

  logic [7:0]  idx, br_mask, imp_v;
  logic [15:0] pc1, st_addr, st_pull, br_off;
  logic        is_store, br_take;
  assign pc1     = pc_r + 16'd1;
  assign st_addr = {c6502_pkg::STACK_PAGE, s_r};
  assign st_pull = {c6502_pkg::STACK_PAGE, s_r + 8'd1};
  assign is_store = dec.op == c6502_pkg::O_STA || dec.op == c6502_pkg::O_STX ||
                    dec.op == c6502_pkg::O_STY;
  assign br_off  = {{8{rd[7]}}, rd};

  always_comb begin
    idx = 8'd0;
    case (dec.mode)
      c6502_pkg::M_ZPX, c6502_pkg::M_ABX, c6502_pkg::M_IZX: idx = x_r;
      c6502_pkg::M_ZPY, c6502_pkg::M_ABY, c6502_pkg::M_IZY: idx = y_r;
      default: ;
    endcase
    case (opc_r[7:6])
      2'd0: br_mask = 8'h80;
      2'd1: br_mask = 8'h40;
      2'd2: br_mask = 8'h01;
      default: br_mask = 8'h02;
    endcase
    br_take = (((p_r & br_mask) != 8'd0) == opc_r[5]);
  end

  // main next-state logic; boundary handling is folded in at the end
  always_comb begin
    logic        bnd, ill;
    logic [15:0] ea;
    logic        ea_go;
    a_nxt = a_r; x_nxt = x_r; y_nxt = y_r; s_nxt = s_r; p_nxt = p_r;
    pc_nxt = pc_r; at_nxt = at_r; dt_nxt = dt_r; opc_nxt = opc_r;
    ph_nxt = ph_r; kind_nxt = kind_r;
    nmi_nxt = nmi_r | in_ch.data.nmi_pulse;
    req = '0;
    bnd = 1'b0; ill = 1'b0; ea = 16'd0; ea_go = 1'b0;
    imp_v = 8'd0;

    if (kind_r != c6502_pkg::K_INSTR || (ph_r != 3'd0 && opc_r == c6502_pkg::OPC_BRK)) begin
      // push / vector sequence for brk, irq, nmi and reset
      case (ph_r)
        3'd1: begin
          req.bus_address = st_addr; req.bus_write = 1'b1; req.write_data = pc_r[7:0];
          s_nxt = s_r - 8'd1; ph_nxt = 3'd2;
        end
        3'd2: begin
          req.bus_address = st_addr; req.bus_write = 1'b1;
          req.write_data = (kind_r == c6502_pkg::K_INSTR) ?
                           (p_r | c6502_pkg::FL_B | c6502_pkg::FL_U) :
                           ((p_r & c6502_pkg::PULL_MASK) | c6502_pkg::FL_U);
          s_nxt = s_r - 8'd1;
          p_nxt = p_r | 8'h04;
          at_nxt = (kind_r == c6502_pkg::K_NMI) ? c6502_pkg::VEC_NMI : c6502_pkg::VEC_IRQ;
          ph_nxt = 3'd3;
        end
        3'd3: begin req.bus_address = at_r; ph_nxt = 3'd4; end
        3'd4: begin dt_nxt = rd; req.bus_address = at_r + 16'd1; ph_nxt = 3'd5; end
        3'd5: begin pc_nxt = {rd, dt_r}; bnd = 1'b1; end
        default: bnd = 1'b1;
      endcase
    end else if (ph_r == 3'd0) begin
      // opcode fetch completed
      opc_nxt = rd;
      pc_nxt  = pc1;
      case (dec.mode)
        c6502_pkg::M_ILL: begin bnd = 1'b1; ill = 1'b1; end
        c6502_pkg::M_IMP: begin
          bnd = 1'b1;
          case (rd)
            8'h18: p_nxt[0] = 1'b0;
            8'h38: p_nxt[0] = 1'b1;
            8'h58: p_nxt[2] = 1'b0;
            8'h78: p_nxt[2] = 1'b1;
            8'hB8: p_nxt[6] = 1'b0;
            8'hD8: p_nxt[3] = 1'b0;
            8'hF8: p_nxt[3] = 1'b1;
            8'h88: begin imp_v = y_r - 8'd1; y_nxt = imp_v; end
            8'hC8: begin imp_v = y_r + 8'd1; y_nxt = imp_v; end
            8'hCA: begin imp_v = x_r - 8'd1; x_nxt = imp_v; end
            8'hE8: begin imp_v = x_r + 8'd1; x_nxt = imp_v; end
            8'hA8: begin imp_v = a_r; y_nxt = imp_v; end
            8'hAA: begin imp_v = a_r; x_nxt = imp_v; end
            8'h98: begin imp_v = y_r; a_nxt = imp_v; end
            8'h8A: begin imp_v = x_r; a_nxt = imp_v; end
            8'h9A: s_nxt = x_r;
            8'hBA: begin imp_v = s_r; x_nxt = imp_v; end
            default: ;
          endcase
          case (rd)
            8'h88, 8'hC8, 8'hCA, 8'hE8, 8'hA8, 8'hAA, 8'h98, 8'h8A, 8'hBA: begin
              p_nxt[1] = (imp_v == 8'd0); p_nxt[7] = imp_v[7];
            end
            default: ;
          endcase
        end
        c6502_pkg::M_ACC: begin a_nxt = alu_res; p_nxt = alu_p; bnd = 1'b1; end
        c6502_pkg::M_SPC: begin
          case (rd)
            c6502_pkg::OPC_BRK: begin
              pc_nxt = pc_r + 16'd2;
              req.bus_address = st_addr; req.bus_write = 1'b1; req.write_data = pc_nxt[15:8];
              s_nxt = s_r - 8'd1; ph_nxt = 3'd1;
            end
            c6502_pkg::OPC_PHP: begin
              req.bus_address = st_addr; req.bus_write = 1'b1;
              req.write_data = p_r | c6502_pkg::FL_B | c6502_pkg::FL_U;
              s_nxt = s_r - 8'd1; ph_nxt = 3'd6;
            end
            c6502_pkg::OPC_PHA: begin
              req.bus_address = st_addr; req.bus_write = 1'b1; req.write_data = a_r;
              s_nxt = s_r - 8'd1; ph_nxt = 3'd6;
            end
            c6502_pkg::OPC_PLP, c6502_pkg::OPC_PLA: begin
              req.bus_address = st_pull; s_nxt = s_r + 8'd1; ph_nxt = 3'd6;
            end
            c6502_pkg::OPC_RTI, c6502_pkg::OPC_RTS: begin
              req.bus_address = st_pull; s_nxt = s_r + 8'd1; ph_nxt = 3'd1;
            end
            default: begin req.bus_address = pc1; ph_nxt = 3'd1; end
          endcase
        end
        default: begin req.bus_address = pc1; ph_nxt = 3'd1; end
      endcase
    end else begin
      // later cycles of an instruction
      case (opc_r)
        c6502_pkg::OPC_PHP, c6502_pkg::OPC_PHA: bnd = 1'b1;
        c6502_pkg::OPC_PLP: begin
          p_nxt = (rd & c6502_pkg::PULL_MASK) | c6502_pkg::FL_U; bnd = 1'b1;
        end
        c6502_pkg::OPC_PLA: begin
          a_nxt = rd; p_nxt[1] = (rd == 8'd0); p_nxt[7] = rd[7]; bnd = 1'b1;
        end
        c6502_pkg::OPC_RTS: begin
          if (ph_r == 3'd1) begin
            dt_nxt = rd; req.bus_address = st_pull; s_nxt = s_r + 8'd1; ph_nxt = 3'd2;
          end else begin
            pc_nxt = {rd, dt_r} + 16'd1; bnd = 1'b1;
          end
        end
        c6502_pkg::OPC_RTI: begin
          if (ph_r == 3'd1) begin
            p_nxt = (rd & c6502_pkg::PULL_MASK) | c6502_pkg::FL_U;
            req.bus_address = st_pull; s_nxt = s_r + 8'd1; ph_nxt = 3'd2;
          end else if (ph_r == 3'd2) begin
            dt_nxt = rd; req.bus_address = st_pull; s_nxt = s_r + 8'd1; ph_nxt = 3'd3;
          end else begin
            pc_nxt = {rd, dt_r}; bnd = 1'b1;
          end
        end
        c6502_pkg::OPC_JSR: begin
          if (ph_r == 3'd1) begin
            dt_nxt = rd; pc_nxt = pc1;
            req.bus_address = st_addr; req.bus_write = 1'b1; req.write_data = pc1[15:8];
            s_nxt = s_r - 8'd1; ph_nxt = 3'd2;
          end else if (ph_r == 3'd2) begin
            req.bus_address = st_addr; req.bus_write = 1'b1; req.write_data = pc_r[7:0];
            s_nxt = s_r - 8'd1; ph_nxt = 3'd3;
          end else if (ph_r == 3'd3) begin
            req.bus_address = pc_r; ph_nxt = 3'd4;
          end else begin
            pc_nxt = {rd, dt_r}; bnd = 1'b1;
          end
        end
        c6502_pkg::OPC_JMP, c6502_pkg::OPC_JMI: begin
          if (ph_r == 3'd1) begin
            dt_nxt = rd; pc_nxt = pc1; req.bus_address = pc1; ph_nxt = 3'd2;
          end else if (ph_r == 3'd2 && opc_r == c6502_pkg::OPC_JMI) begin
            at_nxt = {rd, dt_r}; req.bus_address = {rd, dt_r}; ph_nxt = 3'd3;
          end else if (ph_r == 3'd3) begin
            // indirect high byte stays in the pointer's page
            dt_nxt = rd;
            req.bus_address = (at_r & c6502_pkg::PAGE_MASK) | {8'd0, at_r[7:0] + 8'd1};
            ph_nxt = 3'd4;
          end else begin
            pc_nxt = {rd, dt_r}; bnd = 1'b1;
          end
        end
        default: begin
          if (dec.mode == c6502_pkg::M_REL) begin
            pc_nxt = br_take ? (pc1 + br_off) : pc1; bnd = 1'b1;
          end else if (dec.mode == c6502_pkg::M_IMM) begin
            pc_nxt = pc1; a_nxt = alu_a; x_nxt = alu_x; y_nxt = alu_y; p_nxt = alu_p;
            bnd = 1'b1;
          end else if (ph_r == 3'd7) begin
            bnd = 1'b1;
          end else if (ph_r == 3'd6) begin
            if (alu_rmw) begin
              dt_nxt = alu_res; p_nxt = alu_p;
              req.bus_address = at_r; req.bus_write = 1'b1; req.write_data = alu_res;
              ph_nxt = 3'd7;
            end else begin
              if (!is_store) begin
                a_nxt = alu_a; x_nxt = alu_x; y_nxt = alu_y; p_nxt = alu_p;
              end
              bnd = 1'b1;
            end
          end else begin
            case (dec.mode)
              c6502_pkg::M_ZP, c6502_pkg::M_ZPX, c6502_pkg::M_ZPY: begin
                pc_nxt = pc1; ea = {8'd0, rd + idx}; ea_go = 1'b1;
              end
              c6502_pkg::M_ABS, c6502_pkg::M_ABX, c6502_pkg::M_ABY: begin
                pc_nxt = pc1;
                if (ph_r == 3'd1) begin
                  dt_nxt = rd; req.bus_address = pc1; ph_nxt = 3'd2;
                end else begin
                  ea = {rd, dt_r} + {8'd0, idx}; ea_go = 1'b1;
                end
              end
              c6502_pkg::M_IZX, c6502_pkg::M_IZY: begin
                if (ph_r == 3'd1) begin
                  pc_nxt = pc1;
                  at_nxt = {8'd0, (dec.mode == c6502_pkg::M_IZX) ? rd + idx : rd};
                  req.bus_address = at_nxt; ph_nxt = 3'd2;
                end else if (ph_r == 3'd2) begin
                  dt_nxt = rd; req.bus_address = {8'd0, at_r[7:0] + 8'd1}; ph_nxt = 3'd3;
                end else begin
                  ea = {rd, dt_r} + ((dec.mode == c6502_pkg::M_IZY) ? {8'd0, idx} : 16'd0);
                  ea_go = 1'b1;
                end
              end
              default: bnd = 1'b1;
            endcase
          end
        end
      endcase
    end

    // effective address ready: issue the data access
    if (ea_go) begin
      at_nxt = ea; req.bus_address = ea; ph_nxt = 3'd6;
      case (dec.op)
        c6502_pkg::O_STA: begin req.bus_write = 1'b1; req.write_data = a_r; end
        c6502_pkg::O_STX: begin req.bus_write = 1'b1; req.write_data = x_r; end
        c6502_pkg::O_STY: begin req.bus_write = 1'b1; req.write_data = y_r; end
        default: ;
      endcase
    end

    // instruction boundary: interrupt check, else opcode fetch
    if (bnd) begin
      kind_nxt = c6502_pkg::K_INSTR;
      if (nmi_nxt || (in_ch.data.irq_line && !p_nxt[2])) begin
        kind_nxt = nmi_nxt ? c6502_pkg::K_NMI : c6502_pkg::K_IRQ;
        nmi_nxt = 1'b0;
        req.bus_address = {c6502_pkg::STACK_PAGE, s_nxt};
        req.bus_write = 1'b1; req.write_data = pc_nxt[15:8];
        s_nxt = s_nxt - 8'd1;
        ph_nxt = 3'd1;
      end else begin
        req.bus_address = pc_nxt; req.bus_write = 1'b0; req.write_data = 8'd0;
        req.instr_end = 1'b1; ph_nxt = 3'd0;
      end
      req.illegal_opcode = ill;
    end

    // restart through the reset vector
    if (in_ch.data.cmd) begin
      a_nxt = 8'd0; x_nxt = 8'd0; y_nxt = 8'd0; s_nxt = c6502_pkg::SP_RESET;
      p_nxt = c6502_pkg::P_RESET; pc_nxt = 16'd0; opc_nxt = 8'd0; dt_nxt = 8'd0;
      nmi_nxt = 1'b0; kind_nxt = c6502_pkg::K_RESET; ph_nxt = 3'd4;
      at_nxt = c6502_pkg::VEC_RESET;
      req = '0; req.bus_address = c6502_pkg::VEC_RESET;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= 8'd0; x_r <= 8'd0; y_r <= 8'd0; s_r <= c6502_pkg::SP_RESET;
      p_r <= c6502_pkg::P_RESET; pc_r <= 16'd0; opc_r <= 8'd0; dt_r <= 8'd0;
      at_r <= c6502_pkg::VEC_RESET; ph_r <= 3'd4; kind_r <= c6502_pkg::K_RESET;
      nmi_r <= 1'b0; res_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        a_r <= a_nxt; x_r <= x_nxt; y_r <= y_nxt; s_r <= s_nxt; p_r <= p_nxt;
        pc_r <= pc_nxt; opc_r <= opc_nxt; dt_r <= dt_nxt; at_r <= at_nxt;
        ph_r <= ph_nxt; kind_r <= kind_nxt; nmi_r <= nmi_nxt;
        res_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) res_r <= req;
  end

  // status bit 5 is always set and bit 4 always clear in the register
  a_p_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    p_r[5] && !p_r[4]) else $error("status packing broken");

  // a held result stays put while the receiver stalls
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld_r && !out_ch.ready) |=> $stable(res_r)) else $error("result changed");

  // opcode fetch is always a read
  a_fetch_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld_r && res_r.instr_end) |-> !res_r.bus_write) else $error("fetch wrote");

  // a restart always requests the reset vector
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.data.cmd) |=> (res_r.bus_address == c6502_pkg::VEC_RESET))
    else $error("restart missed vector");

endmodule

// File: verif/tb_top.sv
// tb_top: self-checking testbench for cpu_6502_instruction_core
// depends on c6502_pkg, c6502_in_if, c6502_out_if and the core itself
// a cycle-level model of the core predicts each bus access; the stimulus answers its reads
`timescale 1ns / 100ps

module tb_top;

  // opcodes used by the model and by the directed tests
  localparam logic [7:0] OPC_CLC = 8'h18, OPC_SEC = 8'h38, OPC_CLI = 8'h58, OPC_SEI = 8'h78;
  localparam logic [7:0] OPC_CLV = 8'hB8, OPC_CLD = 8'hD8, OPC_SED = 8'hF8;
  localparam logic [7:0] OPC_DEY = 8'h88, OPC_INY = 8'hC8, OPC_DEX = 8'hCA, OPC_INX = 8'hE8;
  localparam logic [7:0] OPC_TAY = 8'hA8, OPC_TAX = 8'hAA, OPC_TYA = 8'h98, OPC_TXA = 8'h8A;
  localparam logic [7:0] OPC_TXS = 8'h9A, OPC_TSX = 8'hBA, OPC_LDX_IMM = 8'hA2;
  localparam logic [7:0] OPC_BIT_IMM = 8'h89, OPC_LDY_ABX = 8'hBC;
  localparam logic [7:0] OPC_LDA_IMM = 8'hA9, OPC_ADC_IMM = 8'h69, OPC_SBC_IMM = 8'hE9;
  localparam logic [7:0] OPC_ASL_A = 8'h0A, OPC_CMP_IMM = 8'hC9, OPC_UNDEF = 8'h02;
  localparam logic [7:0] OPC_INC_ZPX = 8'hF6, OPC_STA_IZY = 8'h91, OPC_BNE = 8'hD0;

  localparam int BIT_C = 0, BIT_Z = 1, BIT_I = 2, BIT_D = 3, BIT_V = 6, BIT_N = 7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  c6502_in_if  in_ch ();
  c6502_out_if out_ch ();

  cpu_6502_instruction_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // cpu model: architectural registers plus the pending bus access
  // ---------------------------------------------------------------------------
  logic [7:0]  cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p, cpu_opc, cpu_dtmp;
  logic [15:0] cpu_pc, cpu_atmp;
  logic [2:0]  cpu_phase;
  logic        cpu_nmi_pend, cpu_irq_now;
  c6502_pkg::kind_t cpu_kind;

  // the access currently requested by the model
  logic [15:0] acc_addr;
  logic        acc_wr, acc_fetch, acc_ill;
  logic [7:0]  acc_data;

  c6502_pkg::out_item_t access_q[$];
  int        fail_count = 0;

  function automatic c6502_pkg::dec_t decode_opcode(logic [7:0] opc);
    logic [2:0] a, b;
    c6502_pkg::dec_t d;
    a = opc[7:5];
    b = opc[4:2];
    d.op = c6502_pkg::O_NONE;
    d.mode = c6502_pkg::M_ILL;
    case (opc[1:0])
      2'd1: begin
        if (opc != OPC_BIT_IMM) begin
          d.op = c6502_pkg::op_t'(5'(a));
          case (b)
            3'd0: d.mode = c6502_pkg::M_IZX;
            3'd1: d.mode = c6502_pkg::M_ZP;
            3'd2: d.mode = c6502_pkg::M_IMM;
            3'd3: d.mode = c6502_pkg::M_ABS;
            3'd4: d.mode = c6502_pkg::M_IZY;
            3'd5: d.mode = c6502_pkg::M_ZPX;
            3'd6: d.mode = c6502_pkg::M_ABY;
            default: d.mode = c6502_pkg::M_ABX;
          endcase
        end
      end
      2'd2: begin
        d.op = c6502_pkg::op_t'(5'(8 + a));
        case (b)
          3'd0: d.mode = (opc == OPC_LDX_IMM) ? c6502_pkg::M_IMM : c6502_pkg::M_ILL;
          3'd1: d.mode = c6502_pkg::M_ZP;
          3'd2: begin
            if (a < 4) d.mode = c6502_pkg::M_ACC;
            else begin
              d.op = c6502_pkg::O_NONE;
              d.mode = c6502_pkg::M_IMP;
            end
          end
          3'd3: d.mode = c6502_pkg::M_ABS;
          3'd5: d.mode = (a == 4 || a == 5) ? c6502_pkg::M_ZPY : c6502_pkg::M_ZPX;
          3'd6: begin
            d.op = c6502_pkg::O_NONE;
            d.mode = (opc == OPC_TXS || opc == OPC_TSX) ? c6502_pkg::M_IMP : c6502_pkg::M_ILL;
          end
          3'd7: d.mode = (a == 4) ? c6502_pkg::M_ILL :
                         (a == 5) ? c6502_pkg::M_ABY : c6502_pkg::M_ABX;
          default: d.mode = c6502_pkg::M_ILL;
        endcase
      end
      2'd0: begin
        case (a)
          3'd1: d.op = c6502_pkg::O_BIT;
          3'd4: d.op = c6502_pkg::O_STY;
          3'd5: d.op = c6502_pkg::O_LDY;
          3'd6: d.op = c6502_pkg::O_CPY;
          3'd7: d.op = c6502_pkg::O_CPX;
          default: d.op = c6502_pkg::O_NONE;
        endcase
        case (b)
          3'd0: d.mode = (a < 4) ? c6502_pkg::M_SPC :
                         (a == 4) ? c6502_pkg::M_ILL : c6502_pkg::M_IMM;
          3'd1: d.mode = (a == 1 || a >= 4) ? c6502_pkg::M_ZP : c6502_pkg::M_ILL;
          3'd2: d.mode = (a < 4) ? c6502_pkg::M_SPC : c6502_pkg::M_IMP;
          3'd3: d.mode = (a == 2 || a == 3) ? c6502_pkg::M_SPC :
                         (a == 0) ? c6502_pkg::M_ILL : c6502_pkg::M_ABS;
          3'd4: d.mode = c6502_pkg::M_REL;
          3'd5: d.mode = (a == 4 || a == 5) ? c6502_pkg::M_ZPX : c6502_pkg::M_ILL;
          3'd6: d.mode = c6502_pkg::M_IMP;
          default: d.mode = (opc == OPC_LDY_ABX) ? c6502_pkg::M_ABX : c6502_pkg::M_ILL;
        endcase
      end
      default: d.mode = c6502_pkg::M_ILL;
    endcase
    return d;
  endfunction

  function automatic void read_at(logic [15:0] adr);
    acc_addr = adr;
    acc_wr = 1'b0;
    acc_data = 8'h00;
    acc_fetch = 1'b0;
  endfunction

  function automatic void write_at(logic [15:0] adr, logic [7:0] v);
    acc_addr = adr;
    acc_wr = 1'b1;
    acc_data = v;
    acc_fetch = 1'b0;
  endfunction

  function automatic void push_byte(logic [7:0] v);
    write_at({c6502_pkg::STACK_PAGE, cpu_sp}, v);
    cpu_sp = cpu_sp - 8'd1;
  endfunction

  function automatic void pull_byte();
    cpu_sp = cpu_sp + 8'd1;
    read_at({c6502_pkg::STACK_PAGE, cpu_sp});
  endfunction

  function automatic void set_nz(logic [7:0] v);
    cpu_p[BIT_Z] = (v == 8'h00);
    cpu_p[BIT_N] = v[7];
  endfunction

  function automatic void compare_with(logic [7:0] r, logic [7:0] v);
    cpu_p[BIT_C] = (r >= v);
    set_nz(r - v);
  endfunction

  function automatic void add_carry(logic [7:0] v);
    logic [8:0] tot;
    tot = {1'b0, cpu_a} + {1'b0, v} + {8'h00, cpu_p[BIT_C]};
    cpu_p[BIT_C] = tot[8];
    cpu_p[BIT_V] = ~(cpu_a[7] ^ v[7]) & (cpu_a[7] ^ tot[7]);
    cpu_a = tot[7:0];
    set_nz(cpu_a);
  endfunction

  function automatic void exec_read(c6502_pkg::op_t op, logic [7:0] v);
    case (op)
      c6502_pkg::O_ORA: begin cpu_a = cpu_a | v; set_nz(cpu_a); end
      c6502_pkg::O_AND: begin cpu_a = cpu_a & v; set_nz(cpu_a); end
      c6502_pkg::O_EOR: begin cpu_a = cpu_a ^ v; set_nz(cpu_a); end
      c6502_pkg::O_ADD: add_carry(v);
      c6502_pkg::O_SUB: add_carry(~v);
      c6502_pkg::O_LDA: begin cpu_a = v; set_nz(v); end
      c6502_pkg::O_LDX: begin cpu_x = v; set_nz(v); end
      c6502_pkg::O_LDY: begin cpu_y = v; set_nz(v); end
      c6502_pkg::O_CPA: compare_with(cpu_a, v);
      c6502_pkg::O_CPX: compare_with(cpu_x, v);
      c6502_pkg::O_CPY: compare_with(cpu_y, v);
      c6502_pkg::O_BIT: begin
        cpu_p[BIT_Z] = ((cpu_a & v) == 8'h00);
        cpu_p[BIT_N] = v[7];
        cpu_p[BIT_V] = v[6];
      end
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] shift_or_step(c6502_pkg::op_t op, logic [7:0] v);
    logic [7:0] r;
    logic       cin;
    r = v;
    cin = cpu_p[BIT_C];
    case (op)
      c6502_pkg::O_ASL: begin r = {v[6:0], 1'b0}; cpu_p[BIT_C] = v[7]; end
      c6502_pkg::O_ROL: begin r = {v[6:0], cin};  cpu_p[BIT_C] = v[7]; end
      c6502_pkg::O_LSR: begin r = {1'b0, v[7:1]}; cpu_p[BIT_C] = v[0]; end
      c6502_pkg::O_ROR: begin r = {cin, v[7:1]};  cpu_p[BIT_C] = v[0]; end
      c6502_pkg::O_DEC: r = v - 8'd1;
      c6502_pkg::O_INC: r = v + 8'd1;
      default: ;
    endcase
    set_nz(r);
    return r;
  endfunction

  function automatic void exec_implied(logic [7:0] opc);
    case (opc)
      OPC_CLC: cpu_p[BIT_C] = 1'b0;
      OPC_SEC: cpu_p[BIT_C] = 1'b1;
      OPC_CLI: cpu_p[BIT_I] = 1'b0;
      OPC_SEI: cpu_p[BIT_I] = 1'b1;
      OPC_CLV: cpu_p[BIT_V] = 1'b0;
      OPC_CLD: cpu_p[BIT_D] = 1'b0;
      OPC_SED: cpu_p[BIT_D] = 1'b1;
      OPC_DEY: begin cpu_y = cpu_y - 8'd1; set_nz(cpu_y); end
      OPC_INY: begin cpu_y = cpu_y + 8'd1; set_nz(cpu_y); end
      OPC_DEX: begin cpu_x = cpu_x - 8'd1; set_nz(cpu_x); end
      OPC_INX: begin cpu_x = cpu_x + 8'd1; set_nz(cpu_x); end
      OPC_TAY: begin cpu_y = cpu_a; set_nz(cpu_y); end
      OPC_TAX: begin cpu_x = cpu_a; set_nz(cpu_x); end
      OPC_TYA: begin cpu_a = cpu_y; set_nz(cpu_a); end
      OPC_TXA: begin cpu_a = cpu_x; set_nz(cpu_a); end
      OPC_TXS: cpu_sp = cpu_x;
      OPC_TSX: begin cpu_x = cpu_sp; set_nz(cpu_x); end
      default: ;
    endcase
  endfunction

  // interrupt check, or else the next opcode fetch
  function automatic void next_instruction(logic ill);
    cpu_kind = c6502_pkg::K_INSTR;
    if (cpu_nmi_pend || (cpu_irq_now && !cpu_p[BIT_I])) begin
      cpu_kind = cpu_nmi_pend ? c6502_pkg::K_NMI : c6502_pkg::K_IRQ;
      cpu_nmi_pend = 1'b0;
      push_byte(cpu_pc[15:8]);
      cpu_phase = 3'd1;
    end else begin
      read_at(cpu_pc);
      acc_fetch = 1'b1;
      cpu_phase = 3'd0;
    end
    acc_ill = ill;
  endfunction

  // brk, irq, nmi and reset: stack pushes then the vector pair
  function automatic void vector_step(logic [7:0] rd);
    case (cpu_phase)
      3'd1: begin push_byte(cpu_pc[7:0]); cpu_phase = 3'd2; end
      3'd2: begin
        push_byte(cpu_kind == c6502_pkg::K_INSTR ?
                  (cpu_p | c6502_pkg::FL_B | c6502_pkg::FL_U) :
                  ((cpu_p & c6502_pkg::PULL_MASK) | c6502_pkg::FL_U));
        cpu_p[BIT_I] = 1'b1;
        cpu_atmp = (cpu_kind == c6502_pkg::K_NMI) ? c6502_pkg::VEC_NMI : c6502_pkg::VEC_IRQ;
        cpu_phase = 3'd3;
      end
      3'd3: begin read_at(cpu_atmp); cpu_phase = 3'd4; end
      3'd4: begin cpu_dtmp = rd; read_at(cpu_atmp + 16'd1); cpu_phase = 3'd5; end
      3'd5: begin cpu_pc = {rd, cpu_dtmp}; next_instruction(1'b0); end
      default: next_instruction(1'b0);
    endcase
  endfunction

  function automatic void operand_ready(c6502_pkg::op_t op, logic [15:0] ea);
    cpu_atmp = ea;
    if (op == c6502_pkg::O_STA) write_at(ea, cpu_a);
    else if (op == c6502_pkg::O_STX) write_at(ea, cpu_x);
    else if (op == c6502_pkg::O_STY) write_at(ea, cpu_y);
    else read_at(ea);
    cpu_phase = 3'd6;
  endfunction

  function automatic void opcode_arrived(logic [7:0] rd);
    c6502_pkg::dec_t d;
    d = decode_opcode(rd);
    cpu_opc = rd;
    cpu_pc = cpu_pc + 16'd1;
    case (d.mode)
      c6502_pkg::M_ILL: next_instruction(1'b1);
      c6502_pkg::M_IMP: begin exec_implied(rd); next_instruction(1'b0); end
      c6502_pkg::M_ACC: begin cpu_a = shift_or_step(d.op, cpu_a); next_instruction(1'b0); end
      c6502_pkg::M_SPC: begin
        if (rd == c6502_pkg::OPC_BRK) begin
          cpu_pc = cpu_pc + 16'd1;
          push_byte(cpu_pc[15:8]);
          cpu_phase = 3'd1;
        end else if (rd == c6502_pkg::OPC_PHP) begin
          push_byte(cpu_p | c6502_pkg::FL_B | c6502_pkg::FL_U);
          cpu_phase = 3'd6;
        end else if (rd == c6502_pkg::OPC_PHA) begin
          push_byte(cpu_a);
          cpu_phase = 3'd6;
        end else if (rd == c6502_pkg::OPC_PLP || rd == c6502_pkg::OPC_PLA) begin
          pull_byte();
          cpu_phase = 3'd6;
        end else if (rd == c6502_pkg::OPC_RTI || rd == c6502_pkg::OPC_RTS) begin
          pull_byte();
          cpu_phase = 3'd1;
        end else begin
          read_at(cpu_pc);
          cpu_phase = 3'd1;
        end
      end
      default: begin read_at(cpu_pc); cpu_phase = 3'd1; end
    endcase
  endfunction

  function automatic void instr_step(logic [7:0] rd);
    c6502_pkg::dec_t d;
    logic [7:0] idx, mask;
    logic [2:0] ph;
    d = decode_opcode(cpu_opc);
    ph = cpu_phase;
    idx = (d.mode inside {c6502_pkg::M_ZPX, c6502_pkg::M_ABX, c6502_pkg::M_IZX}) ? cpu_x :
          (d.mode inside {c6502_pkg::M_ZPY, c6502_pkg::M_ABY, c6502_pkg::M_IZY}) ? cpu_y :
          8'h00;
    case (cpu_opc)
      c6502_pkg::OPC_PHP, c6502_pkg::OPC_PHA: begin next_instruction(1'b0); return; end
      c6502_pkg::OPC_PLP: begin
        cpu_p = (rd & c6502_pkg::PULL_MASK) | c6502_pkg::FL_U;
        next_instruction(1'b0);
        return;
      end
      c6502_pkg::OPC_PLA: begin cpu_a = rd; set_nz(rd); next_instruction(1'b0); return; end
      c6502_pkg::OPC_RTS: begin
        if (ph == 3'd1) begin cpu_dtmp = rd; pull_byte(); cpu_phase = 3'd2; end
        else begin cpu_pc = {rd, cpu_dtmp} + 16'd1; next_instruction(1'b0); end
        return;
      end
      c6502_pkg::OPC_RTI: begin
        if (ph == 3'd1) begin
          cpu_p = (rd & c6502_pkg::PULL_MASK) | c6502_pkg::FL_U;
          pull_byte();
          cpu_phase = 3'd2;
        end else if (ph == 3'd2) begin
          cpu_dtmp = rd;
          pull_byte();
          cpu_phase = 3'd3;
        end else begin
          cpu_pc = {rd, cpu_dtmp};
          next_instruction(1'b0);
        end
        return;
      end
      c6502_pkg::OPC_JSR: begin
        if (ph == 3'd1) begin
          cpu_dtmp = rd;
          cpu_pc = cpu_pc + 16'd1;
          push_byte(cpu_pc[15:8]);
          cpu_phase = 3'd2;
        end else if (ph == 3'd2) begin
          push_byte(cpu_pc[7:0]);
          cpu_phase = 3'd3;
        end else if (ph == 3'd3) begin
          read_at(cpu_pc);
          cpu_phase = 3'd4;
        end else begin
          cpu_pc = {rd, cpu_dtmp};
          next_instruction(1'b0);
        end
        return;
      end
      c6502_pkg::OPC_JMP, c6502_pkg::OPC_JMI: begin
        if (ph == 3'd1) begin
          cpu_dtmp = rd;
          cpu_pc = cpu_pc + 16'd1;
          read_at(cpu_pc);
          cpu_phase = 3'd2;
        end else if (ph == 3'd2 && cpu_opc == c6502_pkg::OPC_JMI) begin
          cpu_atmp = {rd, cpu_dtmp};
          read_at(cpu_atmp);
          cpu_phase = 3'd3;
        end else if (ph == 3'd3) begin
          // high byte of the pointer comes from the same page
          cpu_dtmp = rd;
          read_at((cpu_atmp & c6502_pkg::PAGE_MASK) | {8'h00, cpu_atmp[7:0] + 8'd1});
          cpu_phase = 3'd4;
        end else begin
          cpu_pc = {rd, cpu_dtmp};
          next_instruction(1'b0);
        end
        return;
      end
      default: ;
    endcase
    if (d.mode == c6502_pkg::M_REL) begin
      case (cpu_opc[7:6])
        2'd0: mask = 8'h80;
        2'd1: mask = 8'h40;
        2'd2: mask = 8'h01;
        default: mask = 8'h02;
      endcase
      cpu_pc = cpu_pc + 16'd1;
      if (((cpu_p & mask) != 8'h00) == cpu_opc[5])
        cpu_pc = cpu_pc + {{8{rd[7]}}, rd};
      next_instruction(1'b0);
      return;
    end
    if (d.mode == c6502_pkg::M_IMM) begin
      cpu_pc = cpu_pc + 16'd1;
      exec_read(d.op, rd);
      next_instruction(1'b0);
      return;
    end
    if (ph == 3'd7) begin next_instruction(1'b0); return; end
    if (ph == 3'd6) begin
      if (d.op inside {c6502_pkg::O_ASL, c6502_pkg::O_ROL, c6502_pkg::O_LSR,
                       c6502_pkg::O_ROR, c6502_pkg::O_DEC, c6502_pkg::O_INC}) begin
        cpu_dtmp = shift_or_step(d.op, rd);
        write_at(cpu_atmp, cpu_dtmp);
        cpu_phase = 3'd7;
        return;
      end
      if (!(d.op inside {c6502_pkg::O_STA, c6502_pkg::O_STX, c6502_pkg::O_STY}))
        exec_read(d.op, rd);
      next_instruction(1'b0);
      return;
    end
    case (d.mode)
      c6502_pkg::M_ZP, c6502_pkg::M_ZPX, c6502_pkg::M_ZPY: begin
        cpu_pc = cpu_pc + 16'd1;
        operand_ready(d.op, {8'h00, rd + idx});
      end
      c6502_pkg::M_ABS, c6502_pkg::M_ABX, c6502_pkg::M_ABY: begin
        cpu_pc = cpu_pc + 16'd1;
        if (ph == 3'd1) begin
          cpu_dtmp = rd;
          read_at(cpu_pc);
          cpu_phase = 3'd2;
        end else begin
          operand_ready(d.op, {rd, cpu_dtmp} + {8'h00, idx});
        end
      end
      c6502_pkg::M_IZX, c6502_pkg::M_IZY: begin
        if (ph == 3'd1) begin
          cpu_pc = cpu_pc + 16'd1;
          cpu_atmp = {8'h00, (d.mode == c6502_pkg::M_IZX) ? rd + idx : rd};
          read_at(cpu_atmp);
          cpu_phase = 3'd2;
        end else if (ph == 3'd2) begin
          cpu_dtmp = rd;
          read_at({8'h00, cpu_atmp[7:0] + 8'd1});
          cpu_phase = 3'd3;
        end else begin
          operand_ready(d.op, {rd, cpu_dtmp} +
                        {8'h00, (d.mode == c6502_pkg::M_IZY) ? idx : 8'h00});
        end
      end
      default: next_instruction(1'b0);
    endcase
  endfunction

  function automatic void cpu_restart();
    cpu_a = 8'h00; cpu_x = 8'h00; cpu_y = 8'h00;
    cpu_sp = c6502_pkg::SP_RESET; cpu_p = c6502_pkg::P_RESET;
    cpu_pc = 16'h0000; cpu_opc = 8'h00; cpu_dtmp = 8'h00;
    cpu_nmi_pend = 1'b0; cpu_irq_now = 1'b0;
    cpu_kind = c6502_pkg::K_RESET; cpu_phase = 3'd4;
    cpu_atmp = c6502_pkg::VEC_RESET;
    read_at(c6502_pkg::VEC_RESET);
    acc_ill = 1'b0;
  endfunction

  // one completed bus cycle; returns the access the core should request next
  function automatic c6502_pkg::out_item_t bus_cycle(c6502_pkg::in_item_t it);
    c6502_pkg::out_item_t r;
    if (it.cmd) begin
      cpu_restart();
    end else begin
      cpu_irq_now = it.irq_line;
      if (it.nmi_pulse) cpu_nmi_pend = 1'b1;
      acc_ill = 1'b0;
      if (cpu_kind != c6502_pkg::K_INSTR) vector_step(it.read_data);
      else if (cpu_phase == 3'd0) opcode_arrived(it.read_data);
      else if (cpu_opc == c6502_pkg::OPC_BRK) vector_step(it.read_data);
      else instr_step(it.read_data);
    end
    r.bus_address = acc_addr;
    r.bus_write = acc_wr;
    r.write_data = acc_wr ? acc_data : 8'h00;
    r.instr_end = acc_fetch;
    r.illegal_opcode = acc_ill;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: bursts with random gaps
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_request(logic cmd, logic [7:0] rd, logic irq, logic nmi);
    c6502_pkg::in_item_t it;
    int       gap;
    it.cmd = cmd;
    it.read_data = rd;
    it.irq_line = irq;
    it.nmi_pulse = nmi;
    access_q.push_back(bus_cycle(it));
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 4);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // plain read data, no interrupt lines
  task automatic feed(logic [7:0] rd);
    send_request(1'b0, rd, 1'b0, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // result receiver: random stall pattern that changes its share of ready cycles
  // ---------------------------------------------------------------------------
  int ready_pct = 100;
  int stall_tick = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 64 == 63) begin
        case ($urandom_range(0, 3))
          0: ready_pct <= 100;
          1: ready_pct <= 75;
          2: ready_pct <= 40;
          default: ready_pct <= 10;
        endcase
      end
      out_ch.ready <= ($urandom_range(1, 100) <= ready_pct);
    end
  end

  // compare each taken result with the oldest predicted access
  always @(posedge clk) begin
    c6502_pkg::out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (access_q.size() == 0) begin
        $error("unexpected result, address %h", out_ch.data.bus_address);
        fail_count++;
      end else begin
        want = access_q.pop_front();
        if (out_ch.data.bus_address !== want.bus_address) begin
          $error("bus_address: expected %h, got %h", want.bus_address, out_ch.data.bus_address);
          fail_count++;
        end
        if (out_ch.data.bus_write !== want.bus_write) begin
          $error("bus_write: expected %b, got %b", want.bus_write, out_ch.data.bus_write);
          fail_count++;
        end
        if (out_ch.data.write_data !== want.write_data) begin
          $error("write_data: expected %h, got %h", want.write_data, out_ch.data.write_data);
          fail_count++;
        end
        if (out_ch.data.instr_end !== want.instr_end) begin
          $error("instr_end: expected %b, got %b", want.instr_end, out_ch.data.instr_end);
          fail_count++;
        end
        if (out_ch.data.illegal_opcode !== want.illegal_opcode) begin
          $error("illegal_opcode: expected %b, got %b", want.illegal_opcode,
                 out_ch.data.illegal_opcode);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset vector fetch puts the pc at 8000
  task automatic test_reset_vector();
    feed(8'h00);
    feed(8'h80);
  endtask

  // extremes of the alu: overflow, carry out, shift carry
  task automatic test_alu_extremes();
    feed(OPC_LDA_IMM); feed(8'h7F);
    feed(OPC_ADC_IMM); feed(8'hFF);
    feed(OPC_SBC_IMM); feed(8'h80);
    feed(OPC_ASL_A);
    feed(OPC_CMP_IMM); feed(8'h00);
  endtask

  // brk runs with the i flag set; an irq raised with cli is taken at the cli's boundary
  task automatic test_brk_and_irq();
    feed(c6502_pkg::OPC_BRK); feed(8'h00); feed(8'h00); feed(8'h00);
    feed(8'h34); feed(8'h12);
    send_request(1'b0, OPC_CLI, 1'b1, 1'b0);
    send_request(1'b0, OPC_UNDEF, 1'b1, 1'b0);
    feed(8'h00);
  endtask

  // an nmi raised inside the irq sequence is taken when it ends; later bytes feed the nmi sequence, then a restart
  task automatic test_nmi_and_jump();
    send_request(1'b0, OPC_BIT_IMM, 1'b1, 1'b1);
    feed(8'hFF);
    feed(c6502_pkg::OPC_JMI); feed(8'hFF); feed(8'h12); feed(8'hCD); feed(8'hAB);
    send_request(1'b1, 8'hFF, 1'b1, 1'b1);
  endtask

  function automatic logic [7:0] pick_opcode();
    logic [7:0] v;
    c6502_pkg::dec_t d;
    v = 8'($urandom_range(0, 255));
    d = decode_opcode(v);
    while (d.mode == c6502_pkg::M_ILL) begin
      v = 8'($urandom_range(0, 255));
      d = decode_opcode(v);
    end
    return v;
  endfunction

  // random programme: the stimulus answers each fetch with mostly real opcodes
  task automatic test_random_program(int n);
    logic [7:0] rd;
    logic       irq, nmi, cmd;
    for (int i = 0; i < n; i++) begin
      if (acc_fetch && $urandom_range(0, 9) != 0) rd = pick_opcode();
      else rd = 8'($urandom_range(0, 255));
      irq = ($urandom_range(0, 9) == 0);
      nmi = ($urandom_range(0, 59) == 0);
      cmd = ($urandom_range(0, 199) == 0);
      send_request(cmd, rd, irq, nmi);
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cpu_restart();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_vector();
    test_alu_extremes();
    test_brk_and_irq();
    test_nmi_and_jump();
    test_random_program(600);

    in_ch.valid <= 1'b0;
    while (access_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && access_q.size() == 0) begin
      $display("cpu_6502_instruction_core regression: pass");
    end else begin
      $display("cpu_6502_instruction_core regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("cpu_6502_instruction_core regression: fail");
    $finish;
  end

endmodule
